// ===== hdl/pli_pkg.sv =====
// Package for the piecewise linear interpolator: opcodes, status codes, sizes.
// No dependencies.
`timescale 1ns / 1ps
package pli_pkg;
   localparam int MAX_POINTS = 16;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_EVAL  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

// ===== hdl/pli_divider.sv =====
// Serial unsigned 64 by 32 divider, one quotient bit per cycle.
// Depends on pli_pkg.
`timescale 1ns / 1ps
module pli_divider
   import pli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      trial = {rem_ff, quo_ff[63]};
      diff = {1'b0, trial} - {2'b00, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor, so 32 bits hold it.
         if (!diff[33]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: breakpoint memory and sequencer.
// Depends on pli_pkg and pli_divider.
`timescale 1ns / 1ps
//
//  channel   direction  ports                                  beat
//  req       in         req_valid req_ready req_op req_time_req req_value
//  rsp       out        rsp_valid rsp_ready rsp_result rsp_status rsp_single_point
//
// A load walks the sorted table one entry per cycle (one memory read per step),
// then shifts the upper entries up one at a time, a read and a write per entry.
// An evaluate walks the table the same way, reads the two neighbors, multiplies
// and runs the serial divider before the result is summed.
// A clear or an unused opcode goes straight to the response state.
// Reset empties the table at once; the breakpoint memory itself is not cleared.
// The result sits in an output register; while it is not taken no new beat enters.
module piecewise_linear_interpolator
   import pli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic signed [31:0] req_time_req,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic [1:0]  rsp_status,
   output logic        rsp_single_point
);
   // One-hot sequencer states.
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SCAN   = 10'b0000000010, // compare entry idx, read of idx+1 issued
      S_SHIFTR = 10'b0000000100, // read entry idx-1 for shifting up
      S_SHIFTW = 10'b0000001000, // write it to idx
      S_INSERT = 10'b0000010000,
      S_RD1    = 10'b0000100000, // second neighbor in rd_ff: form differences
      S_MUL    = 10'b0001000000,
      S_DIV    = 10'b0010000000,
      S_RESP   = 10'b0100000000,
      S_SUM    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Breakpoint memory: time and value side by side, one read port, one write port.
   logic [63:0] mem [MAX_POINTS];
   logic [63:0] rd_ff;
   logic        we;
   logic [IDX_W-1:0] waddr, raddr;
   logic [63:0] wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [1:0]  op_ff, op_in;
   logic signed [31:0] t_ff, t_in, v_ff, v_in;
   logic signed [31:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [31:0] dx_ff, dx_in, mag_ff, mag_in, dt_ff, dt_in;
   logic        neg_ff, neg_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;
   logic        single_ff, single_in, rv_ff, rv_in;

   div_req_type div_req;
   logic        div_done;
   logic [63:0] quotient;

   pli_divider u_div (
      .clock(clock), .reset(reset), .div_req(div_req),
      .done(div_done), .quotient(quotient)
   );

   logic signed [31:0] rd_t, rd_v;
   logic signed [32:0] dy, sum;
   logic signed [32:0] dtw;
   logic signed [32:0] dxw;

   assign rd_t = rd_ff[63:32];
   assign rd_v = rd_ff[31:0];

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; idx_in = idx_ff; op_in = op_ff;
      t_in = t_ff; v_in = v_ff; x0_in = x0_ff; y0_in = y0_ff;
      dx_in = dx_ff; mag_in = mag_ff; dt_in = dt_ff; neg_in = neg_ff;
      res_in = res_ff; st_in = st_ff;
      single_in = single_ff; rv_in = rv_ff;
      we = 1'b0; waddr = idx_ff[IDX_W-1:0]; wdata = {t_ff, v_ff};
      raddr = idx_ff[IDX_W-1:0];
      div_req = '0;
      dy = 33'(rd_v) - 33'(y0_ff);
      dtw = 33'(t_ff) - 33'(x0_ff);
      dxw = 33'(rd_t) - 33'(x0_ff);
      sum = '0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               op_in = req_op; t_in = req_time_req; v_in = req_value;
               idx_in = '0; raddr = '0; res_in = '0; st_in = ST_OK;
               priority if (req_op == OP_CLEAR) begin
                  cnt_in = '0;
                  state_in = S_RESP;
               end else if (req_op == OP_EVAL && cnt_ff == '0) begin
                  st_in = ST_EMPTY;
                  state_in = S_RESP;
               end else if (req_op == OP_LOAD || req_op == OP_EVAL) begin
                  state_in = (cnt_ff == '0) ? S_INSERT : S_SCAN;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            // rd_ff holds entry idx.
            if (rd_t < t_ff) begin
               x0_in = rd_t; y0_in = rd_v;
               idx_in = idx_ff + CNT_W'(1);
               raddr = idx_in[IDX_W-1:0];
               if (idx_in == cnt_ff) begin
                  if (op_ff == OP_LOAD) begin
                     if (cnt_ff == CNT_W'(MAX_POINTS)) begin
                        st_in = ST_FULL; state_in = S_RESP;
                     end else state_in = S_INSERT;
                  end else begin
                     res_in = rd_v; state_in = S_RESP;
                  end
               end
            end else if (op_ff == OP_LOAD) begin
               if (rd_t == t_ff) state_in = S_RESP;
               else if (cnt_ff == CNT_W'(MAX_POINTS)) begin
                  st_in = ST_FULL; state_in = S_RESP;
               end else begin
                  idx_in = cnt_ff; // shift from the top down to the insert point
                  x0_in = 32'(idx_ff);
                  state_in = S_SHIFTR;
               end
            end else begin
               if (idx_ff == '0 || cnt_ff == CNT_W'(1)) begin
                  res_in = rd_v; state_in = S_RESP;
               end else begin
                  state_in = S_RD1;
               end
            end
         end
         S_SHIFTR: begin
            if (idx_ff == x0_ff[CNT_W-1:0]) begin
               state_in = S_INSERT;
            end else begin
               raddr = idx_ff[IDX_W-1:0] - IDX_W'(1);
               state_in = S_SHIFTW;
            end
         end
         S_SHIFTW: begin
            we = 1'b1; wdata = rd_ff;
            idx_in = idx_ff - CNT_W'(1);
            state_in = S_SHIFTR;
         end
         S_INSERT: begin
            we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            state_in = S_RESP;
         end
         S_RD1: begin
            // rd_ff holds point idx (x1,y1); x0/y0 hold idx-1.
            neg_in = dy[32];
            mag_in = dy[32] ? 32'(-dy) : dy[31:0];
            dt_in = dtw[31:0];
            dx_in = dxw[31:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIV;
            div_req.start = 1'b1;
            div_req.dividend = 64'(mag_ff) * 64'(dt_ff);
            div_req.divisor = dx_ff;
         end
         S_DIV: begin
            if (div_done) state_in = S_SUM;
         end
         S_SUM: begin
            sum = neg_ff ? 33'(y0_ff) - 33'(quotient[32:0])
                         : 33'(y0_ff) + 33'(quotient[32:0]);
            res_in = sum[31:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            single_in = (cnt_ff == CNT_W'(1));
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; op_ff <= op_in; t_ff <= t_in; v_ff <= v_in;
      x0_ff <= x0_in; y0_ff <= y0_in; dx_ff <= dx_in; mag_ff <= mag_in;
      dt_ff <= dt_in; neg_ff <= neg_in; res_ff <= res_in;
      st_ff <= st_in; single_ff <= single_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_result = res_ff;
   assign rsp_status = st_ff;
   assign rsp_single_point = single_ff;
endmodule

// ===== hdl/pli_checker.sv =====
// Port-level checker for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg.
`timescale 1ns / 1ps
module pli_checker
   import pli_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result,
   input logic [1:0]  rsp_status
);
   // A held result is stable.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("result changed while stalled");
   // No new beat enters while a result waits.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");
   // Empty status only carries a zero result.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_result == '0)
      else $error("empty status with nonzero result");
   // A clear never reports an error.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_CLEAR |=> ##1 rsp_status == ST_OK)
      else $error("clear reported error");
endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_op(req_op), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result(rsp_result), .rsp_status(rsp_status)
);
